// ===== hw/rtl/sacl_pkg.sv =====
// sacl_pkg: shared types and constants of the set-associative lru cache
// no dependencies
package sacl_pkg;

  localparam int unsigned DefSets    = 256;
  localparam int unsigned DefWays    = 4;
  localparam int unsigned DefKeyBits = 64;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned HashW      = 32;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned TagW       = 32;
  localparam int unsigned SlotW      = 10;
  localparam int unsigned CntW       = 32;
  localparam int unsigned StampW     = 32;

  localparam logic [CmdW-1:0] CMD_LOOKUP   = 2'd0;
  localparam logic [CmdW-1:0] CMD_ALLOCATE = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAN    = 2'd2;
  localparam logic [CmdW-1:0] CMD_RSVD     = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input item, start set read
    logic resolve;   // compare ways, write back, form result
    logic sweep;     // clear one row, mark it with the current epoch
  } sacl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic epoch_wrap;   // clean takes the epoch back to zero, rows need a sweep
  } sacl_sts_t;

endpackage

// ===== hw/rtl/sacl_if.sv =====
// sacl_in_if / sacl_out_if: valid-ready channels of the cache
// depends on sacl_pkg
interface sacl_in_if import sacl_pkg::*; (input logic clk);
  logic            valid;
  logic            ready;
  logic [CmdW-1:0]  command;
  logic [HashW-1:0] key_hash;
  logic [KeyW-1:0]  key_value;
  logic [TagW-1:0]  entry_tag;
  modport source (output valid, command, key_hash, key_value, entry_tag, input ready);
  modport sink   (input valid, command, key_hash, key_value, entry_tag, output ready);
endinterface

interface sacl_out_if import sacl_pkg::*; (input logic clk);
  logic             valid;
  logic             ready;
  logic             hit;
  logic [SlotW-1:0] slot_index;
  logic [CntW-1:0]  hit_count;
  logic [CntW-1:0]  lookup_count;
  modport source (output valid, hit, slot_index, hit_count, lookup_count, input ready);
  modport sink   (input valid, hit, slot_index, hit_count, lookup_count, output ready);
endinterface

// ===== hw/rtl/sacl_ram.sv =====
// sacl_ram: generic ram with one write port and one registered read port
// no dependencies
module sacl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/sacl_ctrl.sv =====
// sacl_ctrl: sequencer of the cache (clear sweep, read, resolve, result hold)
// depends on sacl_pkg
module sacl_ctrl import sacl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sacl_cmd_t cmd,
  input  sacl_sts_t sts
);
  typedef enum logic [1:0] {S_SWEEP, S_IDLE, S_RESOLVE} state_t;
  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.resolve = (state == S_RESOLVE);
  assign cmd.sweep   = (state == S_SWEEP);

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_SWEEP:   if (sts.sweep_done) state <= S_IDLE;
        S_IDLE:    if (cmd.capture) state <= S_RESOLVE;
        S_RESOLVE: begin
          state     <= sts.epoch_wrap ? S_SWEEP : S_IDLE;
          out_valid <= 1'b1;
        end
        default:   state <= S_SWEEP;
      endcase
    end
  end
endmodule

// ===== hw/rtl/sacl_dp.sv =====
// sacl_dp: set memories, way compare, lru pick, counters and result register
// depends on sacl_pkg, sacl_ram
module sacl_dp import sacl_pkg::*; #(
  parameter int unsigned Sets    = DefSets,
  parameter int unsigned Ways    = DefWays,
  parameter int unsigned KeyBits = DefKeyBits
) (
  input  logic             clk,
  input  logic             rst,
  input  sacl_cmd_t        cmd,
  output sacl_sts_t        sts,
  input  logic [CmdW-1:0]  in_command,
  input  logic [HashW-1:0] in_hash,
  input  logic [KeyW-1:0]  in_key,
  input  logic [TagW-1:0]  in_tag,
  output logic             hit,
  output logic [SlotW-1:0] slot_index,
  output logic [CntW-1:0]  hit_count,
  output logic [CntW-1:0]  lookup_count
);
  localparam int unsigned SetW = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned WayW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned RamD = (Sets > 1) ? Sets : 2;
  // epoch mark per set: a row whose mark differs from the current epoch reads as all invalid
  localparam int unsigned EpW  = 8;
  localparam int unsigned RowW = Ways * (KeyBits + TagW + StampW) + EpW;

  logic [CmdW-1:0]    cmd_r;
  logic [KeyBits-1:0] key_r;
  logic [TagW-1:0]    tag_r;
  logic [SetW-1:0]    set_r, set_in;
  logic [StampW-1:0]  stamp_counter;
  logic [EpW-1:0]     epoch;
  logic [SetW-1:0]    sweep_addr;
  logic               sweep_last;

  logic               we;
  logic [SetW-1:0]    waddr;
  logic [RowW-1:0]    wrow, rrow;

  logic [KeyBits-1:0] k   [Ways];
  logic [TagW-1:0]    t   [Ways];
  logic [StampW-1:0]  s   [Ways];
  logic [Ways-1:0]    match;
  logic               any_hit;
  logic [WayW-1:0]    hit_way, lru_way, sel_way;
  logic [StampW-1:0]  min_s;
  logic               row_valid;
  logic [StampW-1:0]  stamp_next;

  // set number from the hash
  if (Sets > 1) begin : g_set
    assign set_in = SetW'(in_hash % Sets);
  end else begin : g_set1
    assign set_in = '0;
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      key_r <= in_key[KeyBits-1:0];
      tag_r <= in_tag;
      set_r <= set_in;
    end
  end

  sacl_ram #(.Width(RowW), .Depth(RamD)) u_ram (
    .clk, .we, .waddr, .wdata(wrow), .raddr(set_in), .rdata(rrow)
  );

  // unpack the row
  assign row_valid = (rrow[EpW-1:0] == epoch);
  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      k[w] = rrow[EpW + w*(KeyBits+TagW+StampW) +: KeyBits];
      t[w] = rrow[EpW + w*(KeyBits+TagW+StampW) + KeyBits +: TagW];
      s[w] = row_valid ? rrow[EpW + w*(KeyBits+TagW+StampW) + KeyBits + TagW +: StampW] : '0;
      match[w] = (s[w] != '0) && (k[w] == key_r) && (t[w] == tag_r);
    end
  end

  // first matching way and lowest-stamp way
  always_comb begin
    any_hit = 1'b0;
    hit_way = '0;
    lru_way = '0;
    min_s   = s[0];
    for (int w = Ways-1; w >= 0; w--) begin
      if (match[w]) begin
        any_hit = 1'b1;
        hit_way = WayW'(w);
      end
    end
    for (int w = 1; w < Ways; w++) begin
      if (s[w] < min_s) begin
        min_s   = s[w];
        lru_way = WayW'(w);
      end
    end
  end

  assign sel_way    = (cmd_r == CMD_LOOKUP) ? hit_way : lru_way;
  assign stamp_next = (stamp_counter == '1) ? StampW'(1) : stamp_counter + 1'b1;

  // row write: refresh, allocate, or sweep
  always_comb begin
    wrow  = rrow;
    waddr = set_r;
    we    = 1'b0;
    wrow[EpW-1:0] = epoch;
    if (!row_valid) begin
      for (int w = 0; w < Ways; w++)
        wrow[EpW + w*(KeyBits+TagW+StampW) + KeyBits + TagW +: StampW] = '0;
    end
    if (cmd.sweep) begin
      we    = 1'b1;
      waddr = sweep_addr;
      wrow  = '0;
      wrow[EpW-1:0] = epoch;
    end else if (cmd.resolve) begin
      for (int w = 0; w < Ways; w++) begin
        if (WayW'(w) == sel_way) begin
          if (cmd_r == CMD_ALLOCATE) begin
            wrow[EpW + w*(KeyBits+TagW+StampW) +: KeyBits]               = key_r;
            wrow[EpW + w*(KeyBits+TagW+StampW) + KeyBits +: TagW]        = tag_r;
          end
          wrow[EpW + w*(KeyBits+TagW+StampW) + KeyBits + TagW +: StampW] = stamp_counter;
        end
      end
      we = (cmd_r == CMD_ALLOCATE) || (cmd_r == CMD_LOOKUP && any_hit);
    end
  end

  assign sweep_last     = (sweep_addr == SetW'(RamD - 1));
  assign sts.sweep_done = cmd.sweep && sweep_last;
  // a clean that rolls the epoch over must rewrite every row
  assign sts.epoch_wrap = cmd.resolve && (cmd_r == CMD_CLEAN) && (epoch == '1);

  // counters, epoch, sweep address and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= StampW'(1);
      hit_count     <= '0;
      lookup_count  <= '0;
      epoch         <= '0;
      sweep_addr    <= '0;
    end else begin
      if (cmd.sweep) sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      if (cmd.resolve) begin
        hit        <= 1'b0;
        slot_index <= '0;
        case (cmd_r)
          CMD_LOOKUP: begin
            lookup_count <= lookup_count + 1'b1;
            if (any_hit) begin
              hit           <= 1'b1;
              hit_count     <= hit_count + 1'b1;
              stamp_counter <= stamp_next;
              slot_index    <= SlotW'(32'(set_r) * Ways + 32'(hit_way));
            end
          end
          CMD_ALLOCATE: begin
            stamp_counter <= stamp_next;
            slot_index    <= SlotW'(32'(set_r) * Ways + 32'(lru_way));
          end
          CMD_CLEAN: begin
            hit_count    <= '0;
            lookup_count <= '0;
            epoch        <= epoch + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== hw/rtl/set_assoc_cache_timestamp_lru_unit.sv =====
// set_assoc_cache_timestamp_lru_unit: top level of the set-associative lru cache
// depends on sacl_pkg, sacl_if, sacl_ctrl, sacl_dp, sacl_ram
//
//   channel  dir  payload
//   in_ch    in   command, key_hash, key_value, entry_tag
//   out_ch   out  hit, slot_index, hit_count, lookup_count
//
// each item: set row read, then compare and write back through the write
// port of the same row memory; the next item waits until it is resolved.
// after reset a sweep clears every row before the first transfer. a clean
// bumps the current epoch; rows with a stale mark read as invalid. the
// result register holds while out_ch stalls. a clean that rolls the 8-bit
// epoch back to zero sweeps again before the next input transfer.
module set_assoc_cache_timestamp_lru_unit import sacl_pkg::*; #(
  parameter int unsigned SETS     = DefSets,
  parameter int unsigned WAYS     = DefWays,
  parameter int unsigned KEY_BITS = DefKeyBits
) (
  input logic      clk,
  input logic      rst,
  sacl_in_if.sink  in_ch,
  sacl_out_if.source out_ch
);
  sacl_cmd_t cmd;
  sacl_sts_t sts;

  sacl_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  sacl_dp #(.Sets(SETS), .Ways(WAYS), .KeyBits(KEY_BITS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .in_command(in_ch.command), .in_hash(in_ch.key_hash),
    .in_key(in_ch.key_value), .in_tag(in_ch.entry_tag),
    .hit(out_ch.hit), .slot_index(out_ch.slot_index),
    .hit_count(out_ch.hit_count), .lookup_count(out_ch.lookup_count)
  );

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |-> !in_ch.ready) else $error("accept during resolve");
  a_result_after: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |=> out_ch.valid) else $error("missing result");
  a_no_sweep_io: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> !in_ch.ready && !cmd.resolve) else $error("transfer in sweep");
`endif
endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for the set-associative timestamp lru cache
// depends on sacl_pkg, sacl_if and set_assoc_cache_timestamp_lru_unit
module tb_top;
  import sacl_pkg::*;

  localparam int unsigned NSETS = DefSets;
  localparam int unsigned NWAYS = DefWays;
  localparam int unsigned NSLOT = NSETS * NWAYS;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot_index;
    logic [CntW-1:0]  hit_count;
    logic [CntW-1:0]  lookup_count;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sacl_in_if  in_ch  (.clk(clk));
  sacl_out_if out_ch (.clk(clk));

  set_assoc_cache_timestamp_lru_unit DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [KeyW-1:0]   keys_m   [NSLOT];
  logic [TagW-1:0]   tags_m   [NSLOT];
  logic [StampW-1:0] stamps_m [NSLOT];
  logic [StampW-1:0] stamp_ctr;
  logic [CntW-1:0]   hits_m;
  logic [CntW-1:0]   lookups_m;

  cache_result_t expected_results[$];
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;        // no idling in the final part
  bit  hold_off = 1'b0;    // long receiver stall request

  // small pool of keys and sets so lookups hit often
  logic [KeyW-1:0]  key_pool [8];
  logic [TagW-1:0]  tag_pool [4];
  logic [HashW-1:0] hash_pool[6];

  function automatic logic [StampW-1:0] next_stamp();
    logic [StampW-1:0] s;
    s = stamp_ctr;
    stamp_ctr = stamp_ctr + 1;
    if (stamp_ctr == '0) stamp_ctr = 1;
    return s;
  endfunction

  // compute the expected response of one command and update predictor state
  function automatic cache_result_t predict_cache(logic [CmdW-1:0] cmd, logic [HashW-1:0] h,
                                                  logic [KeyW-1:0] k, logic [TagW-1:0] t);
    cache_result_t r;
    int unsigned base;
    int unsigned best;
    r = '0;
    base = (h % NSETS) * NWAYS;
    if (cmd == CMD_LOOKUP) begin
      lookups_m = lookups_m + 1;
      for (int w = 0; w < NWAYS; w++) begin
        if (!r.hit && stamps_m[base+w] != 0 && tags_m[base+w] == t && keys_m[base+w] == k) begin
          hits_m = hits_m + 1;
          stamps_m[base+w] = next_stamp();
          r.hit = 1'b1;
          r.slot_index = SlotW'(base + w);
        end
      end
    end else if (cmd == CMD_ALLOCATE) begin
      best = base;
      for (int w = 1; w < NWAYS; w++)
        if (stamps_m[base+w] < stamps_m[best]) best = base + w;
      stamps_m[best] = next_stamp();
      keys_m[best] = k;
      tags_m[best] = t;
      r.slot_index = SlotW'(best);
    end else if (cmd == CMD_CLEAN) begin
      foreach (stamps_m[i]) stamps_m[i] = '0;
      hits_m = '0;
      lookups_m = '0;
    end
    r.hit_count = hits_m;
    r.lookup_count = lookups_m;
    return r;
  endfunction

  // random idle burst
  task automatic idle_burst();
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  // one transfer on the input channel
  task automatic send_item(logic [CmdW-1:0] cmd, logic [HashW-1:0] h,
                           logic [KeyW-1:0] k, logic [TagW-1:0] t);
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.key_hash  <= h;
    in_ch.key_value <= k;
    in_ch.entry_tag <= t;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_cache(cmd, h, k, t));
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      idle_burst();
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    cache_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result hit=%0d slot=%0d", $time, out_ch.hit,
                 out_ch.slot_index);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.hit !== exp_r.hit) begin
          $display("%0t hit exp %0d got %0d", $time, exp_r.hit, out_ch.hit);
          errors++;
        end
        if (out_ch.slot_index !== exp_r.slot_index) begin
          $display("%0t slot_index exp %0d got %0d", $time, exp_r.slot_index,
                   out_ch.slot_index);
          errors++;
        end
        if (out_ch.hit_count !== exp_r.hit_count) begin
          $display("%0t hit_count exp %0d got %0d", $time, exp_r.hit_count,
                   out_ch.hit_count);
          errors++;
        end
        if (out_ch.lookup_count !== exp_r.lookup_count) begin
          $display("%0t lookup_count exp %0d got %0d", $time, exp_r.lookup_count,
                   out_ch.lookup_count);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // directed: field extremes, all commands, ties, eviction, unused command
  task automatic test_directed();
    send_item(CMD_LOOKUP, '0, '0, '0);                 // miss on empty store
    send_item(CMD_ALLOCATE, '0, '0, '0);               // way 0 on tie
    send_item(CMD_LOOKUP, '0, '0, '0);                 // hit
    send_item(CMD_ALLOCATE, '1, '1, '1);               // last set
    send_item(CMD_LOOKUP, '1, '1, '1);
    send_item(CMD_LOOKUP, '1, '1, 32'hFFFF_FFFE);      // tag mismatch
    send_item(CMD_LOOKUP, '1, 64'h7FFF_FFFF_FFFF_FFFF, '1); // key mismatch
    for (int i = 0; i < 5; i++)                        // fill and evict one set
      send_item(CMD_ALLOCATE, 32'h100 + 7, 64'hA5A5_0000 + i, 32'h5A5A_0000 + i);
    send_item(CMD_LOOKUP, 32'h107, 64'hA5A5_0000, 32'h5A5A_0000); // evicted
    send_item(CMD_LOOKUP, 32'h107, 64'hA5A5_0004, 32'h5A5A_0004);
    send_item(CMD_RSVD, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    send_item(CMD_CLEAN, '0, '0, '0);
    send_item(CMD_LOOKUP, '1, '1, '1);                 // miss after clean
    send_item(CMD_RSVD, '1, '1, '1);
    drain_results();
  endtask

  task automatic random_item();
    logic [CmdW-1:0] cmd;
    logic [HashW-1:0] h;
    logic [KeyW-1:0] k;
    logic [TagW-1:0] t;
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) cmd = CMD_LOOKUP;
    else if (p < 93) cmd = CMD_ALLOCATE;
    else if (p < 97) cmd = CMD_CLEAN;
    else cmd = CMD_RSVD;
    if ($urandom_range(0, 9) < 8) begin
      h = hash_pool[$urandom_range(0, 5)];
      k = key_pool[$urandom_range(0, 7)];
      t = tag_pool[$urandom_range(0, 3)];
    end else begin
      h = $urandom();
      k = {$urandom(), $urandom()};
      t = $urandom();
    end
    send_item(cmd, h, k, t);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) random_item();
  endtask

  // receiver held off while items keep coming, so the input stalls
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(40);
    join
    drain_results();   // sender pause until all results are back
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.command   <= '0;
    in_ch.key_hash  <= '0;
    in_ch.key_value <= '0;
    in_ch.entry_tag <= '0;
    foreach (stamps_m[i]) begin
      stamps_m[i] = '0;
      keys_m[i] = '0;
      tags_m[i] = '0;
    end
    stamp_ctr = 1;
    hits_m = '0;
    lookups_m = '0;
    foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    foreach (hash_pool[i]) hash_pool[i] = $urandom();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(700);
    calm = 1'b1;
    test_random(250);
    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
